// ----- rtl/tis_pkg.sv -----
package tis_pkg;

    localparam int NUM_STEPS = 7;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int TIME_W    = 32;
    localparam int PHASE_W   = 3;
    localparam int RELAY_W   = 4;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_OPEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGN_STOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_CLOSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PURGE_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PURGE_END   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_HOLD    = 3'd6;

    localparam logic [CFG_W-1:0] RST_VALVE_OPEN  = 16'd500;
    localparam logic [CFG_W-1:0] RST_IGN_STOP    = 16'd1500;
    localparam logic [CFG_W-1:0] RST_VALVE_CLOSE = 16'd6000;
    localparam logic [CFG_W-1:0] RST_PURGE_START = 16'd7000;
    localparam logic [CFG_W-1:0] RST_CAMERA      = 16'd7500;
    localparam logic [CFG_W-1:0] RST_PURGE_END   = 16'd12000;
    localparam logic [CFG_W-1:0] RST_ARM_HOLD    = 16'd3000;

    // Sequence steps in firing order; the value after the last one means done.
    localparam logic [STEP_W-1:0] STEP_IGN_ON    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_VALVE_ON  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_IGN_OFF   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_VALVE_OFF = 3'd3;
    localparam logic [STEP_W-1:0] STEP_PURGE_ON  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_CAMERA    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_PURGE_OFF = 3'd6;
    localparam logic [STEP_W-1:0] STEP_DONE      = 3'd7;

    localparam logic [PHASE_W-1:0] PH_ALL_OFF   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IGN_ON    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_VALVE_ON  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_IGN_OFF   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_VALVE_OFF = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PURGING   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FINISHED  = 3'd6;

    // Bit positions in the relay vector.
    localparam int RLY_IGN   = 0;
    localparam int RLY_OX    = 1;
    localparam int RLY_PURGE = 2;
    localparam int RLY_CAM   = 3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_STEP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run_poll;
        logic step_due;
    } dp_status_t;

    function automatic logic [RELAY_W-1:0] step_relays(input logic [STEP_W-1:0] k,
                                                       input logic [RELAY_W-1:0] r);
        logic [RELAY_W-1:0] res;
        res = r;
        case (k)
            STEP_IGN_ON:    res[RLY_IGN]   = 1'b1;
            STEP_VALVE_ON:  res[RLY_OX]    = 1'b1;
            STEP_IGN_OFF:   res[RLY_IGN]   = 1'b0;
            STEP_VALVE_OFF: res[RLY_OX]    = 1'b0;
            STEP_PURGE_ON:  res[RLY_PURGE] = 1'b1;
            STEP_CAMERA:    res[RLY_CAM]   = 1'b1;
            default:        res[RLY_PURGE] = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic [PHASE_W-1:0] step_phase(input logic [STEP_W-1:0] k);
        logic [PHASE_W-1:0] res;
        case (k)
            STEP_IGN_ON:    res = PH_IGN_ON;
            STEP_VALVE_ON:  res = PH_VALVE_ON;
            STEP_IGN_OFF:   res = PH_IGN_OFF;
            STEP_VALVE_OFF: res = PH_VALVE_OFF;
            STEP_PURGE_ON:  res = PH_PURGING;
            STEP_CAMERA:    res = PH_PURGING;
            default:        res = PH_FINISHED;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/tis_ctrl.sv -----
module tis_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tis_pkg::dp_status_t status,
    output tis_pkg::ctrl_cmd_t  cmd
);

    tis_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tis_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = tis_pkg::ST_EVAL;
                end
            end
            tis_pkg::ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.run_poll ? tis_pkg::ST_STEP : tis_pkg::ST_EMIT;
            end
            tis_pkg::ST_STEP: begin
                // One due step fires per cycle; the first step not yet due ends the poll.
                cmd.step = status.step_due;
                if (!status.step_due) begin
                    state_next = tis_pkg::ST_EMIT;
                end
            end
            tis_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = tis_pkg::ST_IDLE;
                end
            end
            default: state_next = tis_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tis_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == tis_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTH
    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a result not yet taken");
    a_step_follows_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tis_pkg::ST_STEP) |-> ($past(state_reg) == tis_pkg::ST_EVAL
                                          || $past(state_reg) == tis_pkg::ST_STEP))
        else $error("step state entered without an evaluation");
    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == tis_pkg::ST_EVAL))
        else $error("captured request not evaluated");
`endif

endmodule

// ----- rtl/tis_dp.sv -----
module tis_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [tis_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tis_pkg::CFG_W-1:0]             cfg_data,
    input  logic [tis_pkg::TIME_W-1:0]            now_ms,
    input  logic                                  ignition_button,
    input  logic                                  all_armed,
    input  logic                                  restart,
    input  tis_pkg::ctrl_cmd_t                    cmd,
    output tis_pkg::dp_status_t                   status,
    output logic [15:0]                           out_data
);

    logic [tis_pkg::CFG_W-1:0] valve_open_reg, ign_stop_reg, valve_close_reg;
    logic [tis_pkg::CFG_W-1:0] purge_start_reg, camera_reg, purge_end_reg, arm_hold_reg;

    logic [tis_pkg::TIME_W-1:0]  now_reg;
    logic                        button_reg, armed_reg, restart_reg;

    logic                        running_reg, running_next;
    logic [tis_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [tis_pkg::TIME_W-1:0]  launch_reg, launch_next;
    logic [tis_pkg::TIME_W-1:0]  hold_reg, hold_next;
    logic [tis_pkg::RELAY_W-1:0] relay_reg, relay_next;
    logic [tis_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        waiting_reg, waiting_next;
    logic [tis_pkg::TIME_W-1:0]  elapsed_reg;
    logic [15:0]                 out_data_reg;

    logic [tis_pkg::CFG_W-1:0]   step_delay;
    logic [tis_pkg::TIME_W-1:0]  held_for;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valve_open_reg  <= tis_pkg::RST_VALVE_OPEN;
            ign_stop_reg    <= tis_pkg::RST_IGN_STOP;
            valve_close_reg <= tis_pkg::RST_VALVE_CLOSE;
            purge_start_reg <= tis_pkg::RST_PURGE_START;
            camera_reg      <= tis_pkg::RST_CAMERA;
            purge_end_reg   <= tis_pkg::RST_PURGE_END;
            arm_hold_reg    <= tis_pkg::RST_ARM_HOLD;
        end else if (cfg_valid) begin
            case (cfg_index)
                tis_pkg::CFG_VALVE_OPEN:  valve_open_reg  <= cfg_data;
                tis_pkg::CFG_IGN_STOP:    ign_stop_reg    <= cfg_data;
                tis_pkg::CFG_VALVE_CLOSE: valve_close_reg <= cfg_data;
                tis_pkg::CFG_PURGE_START: purge_start_reg <= cfg_data;
                tis_pkg::CFG_CAMERA:      camera_reg      <= cfg_data;
                tis_pkg::CFG_PURGE_END:   purge_end_reg   <= cfg_data;
                tis_pkg::CFG_ARM_HOLD:    arm_hold_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Step k is due once the elapsed time reaches the delay of register k-1.
    always_comb begin
        case (step_reg)
            tis_pkg::STEP_VALVE_ON:  step_delay = valve_open_reg;
            tis_pkg::STEP_IGN_OFF:   step_delay = ign_stop_reg;
            tis_pkg::STEP_VALVE_OFF: step_delay = valve_close_reg;
            tis_pkg::STEP_PURGE_ON:  step_delay = purge_start_reg;
            tis_pkg::STEP_CAMERA:    step_delay = camera_reg;
            tis_pkg::STEP_PURGE_OFF: step_delay = purge_end_reg;
            default:                 step_delay = '0;
        endcase
    end

    assign held_for        = now_reg - hold_reg;
    assign status.run_poll = running_reg && !restart_reg;
    assign status.step_due = (step_reg != tis_pkg::STEP_DONE)
                          && (elapsed_reg >= {16'd0, step_delay});

    always_comb begin
        running_next = running_reg;
        step_next    = step_reg;
        launch_next  = launch_reg;
        hold_next    = hold_reg;
        relay_next   = relay_reg;
        phase_next   = phase_reg;
        waiting_next = waiting_reg;
        if (cmd.eval) begin
            waiting_next = 1'b0;
            if (restart_reg) begin
                // Relays and the hold start survive a restart.
                running_next = 1'b0;
                step_next    = tis_pkg::STEP_IGN_ON;
                launch_next  = '0;
                phase_next   = tis_pkg::PH_ALL_OFF;
            end else if (!running_reg) begin
                if (!button_reg) begin
                    hold_next    = now_reg;
                    waiting_next = 1'b1;
                end else if (held_for >= {16'd0, arm_hold_reg} && armed_reg) begin
                    hold_next    = '0;
                    running_next = 1'b1;
                    step_next    = tis_pkg::STEP_IGN_ON;
                    launch_next  = now_reg;
                end
            end
        end else if (cmd.step) begin
            relay_next = tis_pkg::step_relays(step_reg, relay_reg);
            phase_next = tis_pkg::step_phase(step_reg);
            step_next  = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            step_reg    <= tis_pkg::STEP_IGN_ON;
            launch_reg  <= '0;
            hold_reg    <= '0;
            relay_reg   <= '0;
            phase_reg   <= tis_pkg::PH_ALL_OFF;
            waiting_reg <= 1'b0;
        end else begin
            running_reg <= running_next;
            step_reg    <= step_next;
            launch_reg  <= launch_next;
            hold_reg    <= hold_next;
            relay_reg   <= relay_next;
            phase_reg   <= phase_next;
            waiting_reg <= waiting_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg     <= now_ms;
            button_reg  <= ignition_button;
            armed_reg   <= all_armed;
            restart_reg <= restart;
        end
        if (cmd.eval) begin
            elapsed_reg <= now_reg - launch_reg;
        end
        if (cmd.load_out) begin
            out_data_reg <= {6'd0,
                             waiting_reg,
                             (phase_reg == tis_pkg::PH_FINISHED),
                             running_reg,
                             phase_reg,
                             relay_reg[tis_pkg::RLY_CAM],
                             relay_reg[tis_pkg::RLY_PURGE],
                             relay_reg[tis_pkg::RLY_OX],
                             relay_reg[tis_pkg::RLY_IGN]};
        end
    end

    assign out_data = out_data_reg;

`ifndef SYNTH
    a_idle_at_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (step_reg == tis_pkg::STEP_IGN_ON))
        else $error("sequence advanced without a launch");
    a_finished_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == tis_pkg::PH_FINISHED) |-> (step_reg == tis_pkg::STEP_DONE))
        else $error("finished phase with steps still pending");
    a_no_step_past_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (step_reg != tis_pkg::STEP_DONE && running_reg))
        else $error("step fired after the sequence completed");
`endif

endmodule

// ----- rtl/timed_ignition_sequencer_unit.sv -----
// Channel   | Direction | Handshake           | Contents
// s_        | in        | s_tvalid/s_tready   | poll: time, buttons; tuser = restart
// m_        | out       | m_tvalid/m_tready   | relays, phase, running, finished, waiting
// cfg_      | in        | cfg_valid/cfg_ready | register index and 16-bit value
//
// A request passes through capture, evaluation and output; while a sequence runs and
// the request is no restart, a step loop comes between evaluation and output,
// firing at most one due step per cycle.
// A finished result waits in the output register; the next request is accepted
// while it waits, and its own result is held back until the register is free.
// Reset is synchronous on aresetn low; configuration writes are always accepted.
module timed_ignition_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] now_ms, [32] ignition_button, [33] all_armed
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] igniter_drive, [1] oxidizer_relays, [2] purge_relay, [3] camera_signal,
    // [6:4] phase, [7] running, [8] finished, [9] waiting
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tis_pkg::ctrl_cmd_t  cmd;
    tis_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    tis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tis_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .now_ms          (s_tdata[31:0]),
        .ignition_button (s_tdata[32]),
        .all_armed       (s_tdata[33]),
        .restart         (s_tuser),
        .cmd             (cmd),
        .status          (status),
        .out_data        (m_tdata)
    );

endmodule

// ----- test/tb_timed_ignition_sequencer_unit.sv -----
typedef logic [tis_pkg::CFG_W-1:0]     cfg_word_t;
typedef logic [tis_pkg::TIME_W-1:0]    ms_t;
typedef logic [tis_pkg::CFG_IDX_W-1:0] cfg_idx_t;

// Poll request as it travels in s_tdata.
typedef struct packed {
    logic [5:0]                 pad;
    logic                       all_armed;
    logic                       ignition_button;
    logic [tis_pkg::TIME_W-1:0] now_ms;
} poll_t;

// Sequencer outputs as they travel in m_tdata.
typedef struct packed {
    logic [5:0]                  pad;
    logic                        waiting;
    logic                        finished;
    logic                        running;
    logic [tis_pkg::PHASE_W-1:0] phase;
    logic                        camera_signal;
    logic                        purge_relay;
    logic                        oxidizer_relays;
    logic                        igniter_drive;
} seq_result_t;

class sequencer_tracker;
    logic [tis_pkg::CFG_W-1:0]   delay_ms [tis_pkg::NUM_STEPS];
    logic                        launched;
    logic [tis_pkg::STEP_W-1:0]  step_ptr;
    logic [tis_pkg::TIME_W-1:0]  launch_at;
    logic [tis_pkg::TIME_W-1:0]  hold_from;
    logic [tis_pkg::RELAY_W-1:0] relays;
    logic [tis_pkg::PHASE_W-1:0] phase_code;
    seq_result_t                 expected_results [$];
    int                          errors;

    function new();
        delay_ms[tis_pkg::CFG_VALVE_OPEN]  = tis_pkg::RST_VALVE_OPEN;
        delay_ms[tis_pkg::CFG_IGN_STOP]    = tis_pkg::RST_IGN_STOP;
        delay_ms[tis_pkg::CFG_VALVE_CLOSE] = tis_pkg::RST_VALVE_CLOSE;
        delay_ms[tis_pkg::CFG_PURGE_START] = tis_pkg::RST_PURGE_START;
        delay_ms[tis_pkg::CFG_CAMERA]      = tis_pkg::RST_CAMERA;
        delay_ms[tis_pkg::CFG_PURGE_END]   = tis_pkg::RST_PURGE_END;
        delay_ms[tis_pkg::CFG_ARM_HOLD]    = tis_pkg::RST_ARM_HOLD;
        launched   = 1'b0;
        step_ptr   = tis_pkg::STEP_IGN_ON;
        launch_at  = '0;
        hold_from  = '0;
        relays     = '0;
        phase_code = tis_pkg::PH_ALL_OFF;
        errors     = 0;
    endfunction

    function void set_register(logic [tis_pkg::CFG_IDX_W-1:0] idx,
                               logic [tis_pkg::CFG_W-1:0] value);
        if (idx <= tis_pkg::CFG_ARM_HOLD) begin
            delay_ms[idx] = value;
        end
    endfunction

    // Ignition fires at launch; every later step waits for the register before it.
    function logic [tis_pkg::TIME_W-1:0] step_due(logic [tis_pkg::STEP_W-1:0] k);
        if (k == tis_pkg::STEP_IGN_ON) begin
            return '0;
        end
        return ms_t'(delay_ms[k - 3'd1]);
    endfunction

    function void fire_step(logic [tis_pkg::STEP_W-1:0] k);
        case (k)
            tis_pkg::STEP_IGN_ON: begin
                relays[tis_pkg::RLY_IGN] = 1'b1;
                phase_code = tis_pkg::PH_IGN_ON;
            end
            tis_pkg::STEP_VALVE_ON: begin
                relays[tis_pkg::RLY_OX] = 1'b1;
                phase_code = tis_pkg::PH_VALVE_ON;
            end
            tis_pkg::STEP_IGN_OFF: begin
                relays[tis_pkg::RLY_IGN] = 1'b0;
                phase_code = tis_pkg::PH_IGN_OFF;
            end
            tis_pkg::STEP_VALVE_OFF: begin
                relays[tis_pkg::RLY_OX] = 1'b0;
                phase_code = tis_pkg::PH_VALVE_OFF;
            end
            tis_pkg::STEP_PURGE_ON: begin
                relays[tis_pkg::RLY_PURGE] = 1'b1;
                phase_code = tis_pkg::PH_PURGING;
            end
            tis_pkg::STEP_CAMERA: begin
                relays[tis_pkg::RLY_CAM] = 1'b1;
                phase_code = tis_pkg::PH_PURGING;
            end
            default: begin
                relays[tis_pkg::RLY_PURGE] = 1'b0;
                phase_code = tis_pkg::PH_FINISHED;
            end
        endcase
    endfunction

    function void note_poll(poll_t p, logic restart);
        seq_result_t                r;
        logic [tis_pkg::TIME_W-1:0] elapsed;
        logic                       idle_wait;
        idle_wait = 1'b0;
        if (restart) begin
            // Relays and the hold start survive a restart.
            launched   = 1'b0;
            step_ptr   = tis_pkg::STEP_IGN_ON;
            launch_at  = '0;
            phase_code = tis_pkg::PH_ALL_OFF;
        end else if (!launched) begin
            elapsed = p.now_ms - hold_from;
            if (!p.ignition_button) begin
                hold_from = p.now_ms;
                idle_wait = 1'b1;
            end else if (elapsed >= ms_t'(delay_ms[tis_pkg::CFG_ARM_HOLD])
                         && p.all_armed) begin
                hold_from = '0;
                launched  = 1'b1;
                step_ptr  = tis_pkg::STEP_IGN_ON;
                launch_at = p.now_ms;
            end
        end else begin
            elapsed = p.now_ms - launch_at;
            while (step_ptr != tis_pkg::STEP_DONE && elapsed >= step_due(step_ptr)) begin
                fire_step(step_ptr);
                step_ptr = step_ptr + 1'b1;
            end
        end
        r = '0;
        r.igniter_drive   = relays[tis_pkg::RLY_IGN];
        r.oxidizer_relays = relays[tis_pkg::RLY_OX];
        r.purge_relay     = relays[tis_pkg::RLY_PURGE];
        r.camera_signal   = relays[tis_pkg::RLY_CAM];
        r.phase           = phase_code;
        r.running         = launched;
        r.finished        = (phase_code == tis_pkg::PH_FINISHED);
        r.waiting         = idle_wait;
        expected_results.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_outputs(seq_result_t got);
        seq_result_t want;
        if (expected_results.size() == 0) begin
            $error("result %h arrived with no poll outstanding", got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare("igniter_drive", want.igniter_drive, got.igniter_drive);
        compare("oxidizer_relays", want.oxidizer_relays, got.oxidizer_relays);
        compare("purge_relay", want.purge_relay, got.purge_relay);
        compare("camera_signal", want.camera_signal, got.camera_signal);
        compare("phase", want.phase, got.phase);
        compare("running", want.running, got.running);
        compare("finished", want.finished, got.finished);
        compare("waiting", want.waiting, got.waiting);
        compare("padding", want.pad, got.pad);
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_timed_ignition_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT            = 5000;
    localparam int RANDOM_POLLS_PER_PHASE = 205;
    localparam int SETTLE_CYCLES          = 16;
    localparam int NUM_PHASES             = 8;
    localparam logic [tis_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {
        SET_RESET,
        SET_ZERO,
        SET_MAX,
        SET_ORDERED,
        SET_SHUFFLED,
        SET_WIDE,
        SET_EXTREMES,
        SET_COUNT
    } setting_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    sequencer_tracker tracker = new();

    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    int                         polls_sent     = 0;
    int                         idle_cycles    = 0;
    logic [tis_pkg::CFG_W-1:0]  cur_cfg [tis_pkg::NUM_STEPS];
    logic [tis_pkg::TIME_W-1:0] sim_ms;

    timed_ignition_sequencer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_outputs(seq_result_t'(m_tdata));
            end
            if (s_tvalid && s_tready) begin
                tracker.note_poll(poll_t'(s_tdata), s_tuser);
            end
            if (cfg_valid && cfg_ready) begin
                tracker.set_register(cfg_index, cfg_data);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_poll(logic [tis_pkg::TIME_W-1:0] now, logic button, logic armed,
                             logic restart);
        poll_t p;
        p = '0;
        p.now_ms          = now;
        p.ignition_button = button;
        p.all_armed       = armed;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        polls_sent++;
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(bit with_spare);
        for (int i = 0; i < tis_pkg::NUM_STEPS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= tis_pkg::CFG_VALVE_OPEN + cfg_idx_t'(i);
            cfg_data  <= cur_cfg[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        if (with_spare) begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= cfg_word_t'($urandom);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_settings(setting_t kind);
        int acc;
        acc = 0;
        case (kind)
            SET_RESET: begin
                cur_cfg[tis_pkg::CFG_VALVE_OPEN]  = tis_pkg::RST_VALVE_OPEN;
                cur_cfg[tis_pkg::CFG_IGN_STOP]    = tis_pkg::RST_IGN_STOP;
                cur_cfg[tis_pkg::CFG_VALVE_CLOSE] = tis_pkg::RST_VALVE_CLOSE;
                cur_cfg[tis_pkg::CFG_PURGE_START] = tis_pkg::RST_PURGE_START;
                cur_cfg[tis_pkg::CFG_CAMERA]      = tis_pkg::RST_CAMERA;
                cur_cfg[tis_pkg::CFG_PURGE_END]   = tis_pkg::RST_PURGE_END;
                cur_cfg[tis_pkg::CFG_ARM_HOLD]    = tis_pkg::RST_ARM_HOLD;
            end
            SET_ZERO: begin
                foreach (cur_cfg[i]) cur_cfg[i] = '0;
            end
            SET_MAX: begin
                foreach (cur_cfg[i]) cur_cfg[i] = '1;
            end
            SET_SHUFFLED: begin
                foreach (cur_cfg[i]) cur_cfg[i] = cfg_word_t'($urandom_range(0, 150));
            end
            SET_WIDE: begin
                foreach (cur_cfg[i]) cur_cfg[i] = cfg_word_t'($urandom);
            end
            SET_EXTREMES: begin
                foreach (cur_cfg[i]) cur_cfg[i] = $urandom_range(1) ? '1 : '0;
            end
            default: begin
                for (int i = 0; i < tis_pkg::NUM_STEPS - 1; i++) begin
                    acc += $urandom_range(0, 40);
                    cur_cfg[i] = cfg_word_t'(acc);
                end
                cur_cfg[tis_pkg::CFG_ARM_HOLD] = cfg_word_t'($urandom_range(0, 60));
            end
        endcase
    endtask

    function automatic int longest_delay();
        int span;
        span = 1;
        for (int i = 0; i < tis_pkg::NUM_STEPS - 1; i++) begin
            if (int'(cur_cfg[i]) > span) span = cur_cfg[i];
        end
        return span;
    endfunction

    // A release, a held press that should authorize launch, a run of polls
    // walking through the steps and usually a restart; now and then just noise.
    task automatic run_scenario(inout logic [tis_pkg::TIME_W-1:0] t);
        int   span;
        int   hold;
        int   presses;
        int   choice;
        logic armed;
        span = longest_delay();
        hold = cur_cfg[tis_pkg::CFG_ARM_HOLD];
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_poll($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          $urandom_range(3) == 0);
            end
            return;
        end
        if ($urandom_range(7) == 0) begin
            t = 32'hFFFF_FFFF - $urandom_range(0, span + hold);
        end
        repeat ($urandom_range(1, 3)) begin
            t += $urandom_range(0, 50);
            send_poll(t, 1'b0, 1'($urandom_range(1)), 1'b0);
        end
        presses = $urandom_range(2, 5);
        for (int k = 1; k <= presses; k++) begin
            if (k == 1) begin
                t += $urandom_range(0, 5);
            end else begin
                t += hold / (presses - 1) + 1 + $urandom_range(0, 3);
            end
            armed = (k == presses) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
            send_poll(t, $urandom_range(19) != 0, armed, 1'b0);
        end
        repeat ($urandom_range(3, 12)) begin
            choice = $urandom_range(9);
            if (choice >= 8) begin
                t += span + $urandom_range(0, 1000);
            end else if (choice > 0) begin
                t += $urandom_range(0, span / 6 + 1);
            end
            send_poll(t, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        end
        if ($urandom_range(4) != 0) begin
            send_poll(t + $urandom_range(0, 10), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'b1);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset delays: hold check, arming, launch poll, steps one by one and
        // several at once, the finished sequence and restarts.
        send_poll(32'd100, 1'b0, 1'b0, 1'b0);
        send_poll(32'd200, 1'b1, 1'b0, 1'b0);
        send_poll(32'd3100, 1'b1, 1'b0, 1'b0);
        send_poll(32'd3100, 1'b1, 1'b1, 1'b0);
        send_poll(32'd3100, 1'b0, 1'b0, 1'b0);
        send_poll(32'd3600, 1'b1, 1'b1, 1'b0);
        send_poll(32'd4599, 1'b0, 1'b0, 1'b0);
        send_poll(32'd10100, 1'b0, 1'b0, 1'b0);
        send_poll(32'd10599, 1'b1, 1'b0, 1'b0);
        send_poll(32'd10600, 1'b0, 1'b1, 1'b0);
        send_poll(32'd15100, 1'b0, 1'b0, 1'b0);
        send_poll(32'd23100, 1'b1, 1'b1, 1'b0);
        send_poll(32'd0, 1'b1, 1'b1, 1'b1);
        // Hold time and step times measured across the wrap of the clock.
        send_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        send_poll(32'd2998, 1'b1, 1'b1, 1'b0);
        send_poll(32'd2999, 1'b1, 1'b1, 1'b0);
        send_poll(32'd2998, 1'b0, 1'b0, 1'b0);
        send_poll(32'd5000, 1'b1, 1'b1, 1'b1);

        // Delays out of order: a step not yet due holds back later ones.
        drain_results();
        foreach (cur_cfg[i]) cur_cfg[i] = '0;
        cur_cfg[tis_pkg::CFG_VALVE_OPEN] = 16'd1000;
        cur_cfg[tis_pkg::CFG_IGN_STOP]   = 16'd10;
        apply_settings(1'b0);
        send_poll(32'd7, 1'b1, 1'b1, 1'b0);
        send_poll(32'd507, 1'b0, 1'b0, 1'b0);
        send_poll(32'd1007, 1'b0, 1'b0, 1'b0);
        send_poll(32'd1008, 1'b1, 1'b1, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            pick_settings(setting_t'(ph % SET_COUNT));
            apply_settings(setting_t'(ph % SET_COUNT) == SET_WIDE);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            sim_ms     = $urandom;
            polls_sent = 0;
            while (polls_sent < RANDOM_POLLS_PER_PHASE) begin
                run_scenario(sim_ms);
            end
        end

        drain_results();
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
